>>> rtl/lkv_pkg.sv
// lkv_pkg: shared types and codes for the LRU key-value cache.
// Used by lkv_ctrl, lkv_dp and lru_key_value_cache.
`default_nettype none
package lkv_pkg;
  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input word, clear scan state
    logic scan;      // examine slot at scan index
    logic scan_rst;  // scan start marker; masks scan_last
    logic rd_req;    // issue RAM read of hit slot
    logic commit;    // apply update to slot state
    logic done;      // present result
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic scan_last;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// Channel  | Ports                                   | Handshake
// input    | action_i key_i value_i length_i         | start & !busy
// result   | hit_o read_value_o read_length_o evicted_o | done_o, one cycle
// config   | cfg_we_i cfg_data_i (capacity)          | cfg_we_i
// An item passes a serial scan of the key RAM, one slot per cycle, then a
// data RAM read, commit and result register.
// Reset (rst_ni, async, low) clears valid bits, ages, count; capacity to 16.
// The receiver cannot stall; one word is in flight at a time.
// Depends on lkv_pkg, lkv_ctrl, lkv_dp, lkv_ram.
`default_nettype none
module lru_key_value_cache #(
  parameter int Entries  = 16,
  parameter int KeyBits  = 32,
  parameter int DataBits = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                cfg_we_i,
  input  wire logic [4:0]          cfg_data_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [KeyBits-1:0]  key_i,
  input  wire logic [DataBits-1:0] value_i,
  input  wire logic [31:0]         length_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic [DataBits-1:0]      read_value_o,
  output logic [31:0]              read_length_o,
  output logic                     evicted_o
);
  import lkv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lkv_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .sts_i(sts), .cmd_o(cmd));

  lkv_dp #(.Entries(Entries), .KeyBits(KeyBits), .DataBits(DataBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .cfg_we_i, .cfg_data_i,
    .action_i, .key_i, .value_i, .length_i, .done_o, .hit_o, .read_value_o,
    .read_length_o, .evicted_o);
endmodule
`default_nettype wire

>>> rtl/lkv_ram.sv
// lkv_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module lkv_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/lkv_ctrl.sv
// lkv_ctrl: sequencer for one cache word: load, scan, read, commit, respond.
// Depends on lkv_pkg.
`default_nettype none
module lkv_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire lkv_pkg::sts_t sts_i,
  output lkv_pkg::cmd_t      cmd_o
);
  import lkv_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StRead = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StCommit = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_rst = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = StRead;
      end
      StRead: begin
        cmd_o.rd_req = 1'b1;
        state_d = StWait;
      end
      StWait: state_d = StCommit;
      StCommit: begin
        cmd_o.commit = 1'b1;
        cmd_o.done = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == StIdle) else $error("load outside idle");
  a_commit_next_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> !busy_o) else $error("commit not followed by idle");
  a_scan_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.scan) else $error("scan did not follow load");
endmodule
`default_nettype wire

>>> rtl/lkv_dp.sv
// lkv_dp: slot state, serial key/oldest/free scan, data RAMs and result regs.
// Depends on lkv_pkg and lkv_ram.
`default_nettype none
module lkv_dp #(
  parameter int Entries  = 16,
  parameter int KeyBits  = 32,
  parameter int DataBits = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lkv_pkg::cmd_t       cmd_i,
  output lkv_pkg::sts_t            sts_o,
  input  wire logic                cfg_we_i,
  input  wire logic [4:0]          cfg_data_i,
  input  wire logic [1:0]          action_i,
  input  wire logic [KeyBits-1:0]  key_i,
  input  wire logic [DataBits-1:0] value_i,
  input  wire logic [31:0]         length_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic [DataBits-1:0]      read_value_o,
  output logic [31:0]              read_length_o,
  output logic                     evicted_o
);
  import lkv_pkg::*;

  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);

  logic [4:0] cap_q;
  logic [Entries-1:0] valid_q;
  logic [IdxW-1:0] age_q [Entries];
  logic [CntW-1:0] used_q;

  logic [1:0] act_q;
  logic [KeyBits-1:0] key_q;
  logic [DataBits-1:0] val_q;
  logic [31:0] len_q;
  logic [IdxW-1:0] idx_q;
  logic hit_q, old_found_q, free_found_q;
  logic [IdxW-1:0] hit_idx_q, old_idx_q, free_idx_q;

  logic [KeyBits-1:0] key_rd;
  logic [DataBits-1:0] val_rd;
  logic [31:0] len_rd;

  // key RAM read address follows the scan; registered read data arrives in the next cycle
  logic [IdxW-1:0] key_raddr;
  logic scan_pend_q;
  logic [IdxW-1:0] chk_idx_q;
  assign key_raddr = idx_q;

  // effective capacity
  logic [CntW:0] cap_eff;
  always_comb begin
    if (cap_q == 5'd0) cap_eff = (CntW+1)'(1);
    else if ({{(CntW+1){1'b0}}, cap_q} > (CntW+6)'(Entries)) cap_eff = (CntW+1)'(Entries);
    else cap_eff = (CntW+1)'(cap_q);
  end

  logic is_write, is_read, is_remove;
  assign is_write  = (act_q == ACT_WRITE);
  assign is_read   = (act_q == ACT_READ);
  assign is_remove = (act_q == ACT_REMOVE);

  logic need_evict;
  assign need_evict = is_write && !hit_q && ({1'b0, used_q} >= cap_eff) && old_found_q;

  // new slot: lowest free, else the evicted one
  logic [IdxW-1:0] ins_idx;
  assign ins_idx = free_found_q ? free_idx_q : old_idx_q;

  logic [IdxW-1:0] tgt_idx;
  assign tgt_idx = hit_q ? hit_idx_q : ins_idx;

  logic wr_data;
  assign wr_data = cmd_i.commit && is_write;

  lkv_ram #(.Width(KeyBits), .Depth(Entries)) u_key_ram (
    .clk_i, .we_i(wr_data && !hit_q), .waddr_i(ins_idx), .wdata_i(key_q),
    .raddr_i(key_raddr), .rdata_o(key_rd));
  lkv_ram #(.Width(DataBits), .Depth(Entries)) u_val_ram (
    .clk_i, .we_i(wr_data), .waddr_i(tgt_idx), .wdata_i(val_q),
    .raddr_i(hit_idx_q), .rdata_o(val_rd));
  lkv_ram #(.Width(32), .Depth(Entries)) u_len_ram (
    .clk_i, .we_i(wr_data), .waddr_i(tgt_idx), .wdata_i(len_q),
    .raddr_i(hit_idx_q), .rdata_o(len_rd));

  assign sts_o.scan_last = cmd_i.scan && !cmd_i.scan_rst && scan_pend_q
                           && (chk_idx_q == IdxW'(Entries - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 5'd16;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // scan: idx_q issues reads, chk_idx_q checks the returned key in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      scan_pend_q <= 1'b0;
      chk_idx_q <= '0;
      hit_q <= 1'b0;
      old_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
      scan_pend_q <= 1'b0;
      chk_idx_q <= '0;
      hit_q <= 1'b0;
      old_found_q <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (idx_q != IdxW'(Entries - 1)) idx_q <= idx_q + 1'b1;
      scan_pend_q <= 1'b1;
      chk_idx_q <= idx_q;
      if (scan_pend_q) begin
        if (valid_q[chk_idx_q]) begin
          if (!hit_q && key_rd == key_q) begin
            hit_q <= 1'b1;
          end
          if (!old_found_q || age_q[chk_idx_q] > age_q[old_idx_q]) begin
            old_found_q <= 1'b1;
          end
        end else if (!free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      key_q <= key_i;
      val_q <= value_i;
      len_q <= length_i;
    end
    if (cmd_i.scan && scan_pend_q) begin
      if (valid_q[chk_idx_q]) begin
        if (!hit_q && key_rd == key_q) hit_idx_q <= chk_idx_q;
        if (!old_found_q || age_q[chk_idx_q] > age_q[old_idx_q]) old_idx_q <= chk_idx_q;
      end else if (!free_found_q) begin
        free_idx_q <= chk_idx_q;
      end
    end
  end

  // commit: age update (touch / drop / insert), valid, count
  logic [IdxW-1:0] ref_age;
  assign ref_age = hit_q ? age_q[hit_idx_q] : age_q[old_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q <= '0;
      for (int i = 0; i < Entries; i++) age_q[i] <= '0;
    end else if (cmd_i.commit) begin
      if (is_remove && hit_q) begin
        valid_q[hit_idx_q] <= 1'b0;
        age_q[hit_idx_q] <= '0;
        for (int i = 0; i < Entries; i++)
          if (valid_q[i] && age_q[i] > ref_age) age_q[i] <= age_q[i] - 1'b1;
        used_q <= used_q - 1'b1;
      end else if ((is_read || is_write) && hit_q) begin
        for (int i = 0; i < Entries; i++)
          if (valid_q[i] && age_q[i] < ref_age) age_q[i] <= age_q[i] + 1'b1;
        age_q[hit_idx_q] <= '0;
      end else if (is_write) begin
        // new key: optional eviction of oldest, then insert as most recent
        for (int i = 0; i < Entries; i++)
          if (valid_q[i] && !(need_evict && IdxW'(i) == old_idx_q)) begin
            if (need_evict) begin
              if (age_q[i] < ref_age) age_q[i] <= age_q[i] + 1'b1;
            end else begin
              age_q[i] <= age_q[i] + 1'b1;
            end
          end
        if (need_evict) begin
          valid_q[old_idx_q] <= 1'b0;
          age_q[old_idx_q] <= '0;
        end
        valid_q[ins_idx] <= 1'b1;
        age_q[ins_idx] <= '0;
        if (!need_evict) used_q <= used_q + 1'b1;
      end
    end
  end

  // result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      hit_o <= hit_q && (is_write || is_read || is_remove);
      read_value_o <= (is_read && hit_q) ? val_rd : '0;
      read_length_o <= (is_read && hit_q) ? len_rd : '0;
      evicted_o <= need_evict;
    end
  end

  a_used_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntW'(Entries)) else $error("count overflow");
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(used_q)) else $error("count mismatch");
  a_evict_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && need_evict |-> !hit_q) else $error("evict on hit");
endmodule
`default_nettype wire
